FILE: rtl/odd_even_transposition_sort_macros.svh
// Assertion macros for the sorter RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ODD_EVEN_TRANSPOSITION_SORT_MACROS_SVH
`define ODD_EVEN_TRANSPOSITION_SORT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define OETS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define OETS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/oets_pkg.sv
// Types and constants for the odd-even transposition sorter.
// No dependencies.
package oets_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_SHIFT_UP,
    MODE_SORT,
    MODE_SHIFT_DOWN
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  parity;
    cnt_t  count;
  } cell_ctrl_t;

endpackage

FILE: rtl/odd_even_transposition_sort.sv
// Odd-even transposition sorter, top level: a chain of MAX_ITEMS cells and its sequencer.
// Depends on oets_pkg, oets_cell and oets_ctrl.
//
// Requests load one per cycle into the cell chain; up to MAX_ITEMS are kept and the
// rest are dropped, which sets overflow on every result of that sequence. After the
// request marked last_in, the chain runs n parallel compare-exchange rounds (one per
// cycle, n = values held), then unloads n results in ascending signed order, one per
// cycle that out_ready allows, with last_out on the final one. The single chain loads,
// sorts and unloads in turn. No requests are taken during sort or unload.
module odd_even_transposition_sort #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     value,
  input  logic                   last_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     sorted_value,
  output logic                   last_out,
  output logic                   overflow
);

  oets_pkg::cell_ctrl_t ctrl;
  oets_pkg::data_t      cell_val [MAX_ITEMS];

  oets_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_in   (last_in),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last_out  (last_out),
    .overflow  (overflow),
    .ctrl      (ctrl)
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    oets_pkg::data_t lo_nbr;
    oets_pkg::data_t hi_nbr;

    if (i == 0) begin : g_first
      assign lo_nbr = value;
    end else begin : g_mid_lo
      assign lo_nbr = cell_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign hi_nbr = '0;
    end else begin : g_mid_hi
      assign hi_nbr = cell_val[i+1];
    end

    oets_cell #(
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .lo_nbr (lo_nbr),
      .hi_nbr (hi_nbr),
      .val    (cell_val[i])
    );
  end

  assign sorted_value = cell_val[0];

endmodule

FILE: rtl/oets_cell.sv
// One storage cell of the sorter chain: load shift, compare-exchange, unload shift.
// Depends on oets_pkg.
module oets_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  oets_pkg::cell_ctrl_t ctrl,
  input  oets_pkg::data_t      lo_nbr,
  input  oets_pkg::data_t      hi_nbr,
  output oets_pkg::data_t      val
);

  localparam oets_pkg::cnt_t IDX_C  = oets_pkg::CNT_W'(IDX);
  localparam oets_pkg::cnt_t IDX_P1 = oets_pkg::CNT_W'(IDX + 1);
  localparam bit             IDX_LSB = (IDX % 2) == 1;
  localparam bit             HAS_LO  = IDX > 0;

  oets_pkg::data_t val_next;
  oets_pkg::data_t partner;
  logic            is_low;
  logic            active;
  logic            self_gt;

  always_comb begin
    is_low  = (IDX_LSB == ctrl.parity);
    partner = is_low ? hi_nbr : lo_nbr;
    self_gt = val > partner;
    if (is_low) begin
      active = IDX_P1 < ctrl.count;
    end else begin
      active = HAS_LO && (IDX_C < ctrl.count);
    end
    case (ctrl.mode)
      oets_pkg::MODE_SHIFT_UP:   val_next = lo_nbr;
      oets_pkg::MODE_SHIFT_DOWN: val_next = hi_nbr;
      oets_pkg::MODE_SORT: begin
        if (!active) begin
          val_next = val;
        end else if (is_low) begin
          val_next = self_gt ? partner : val;
        end else begin
          val_next = (!self_gt && (val != partner)) ? partner : val;
        end
      end
      default:                   val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: rtl/oets_ctrl.sv
// Sequencer for the sorter: counts loaded requests, steps sort rounds, paces unload.
// Depends on oets_pkg and odd_even_transposition_sort_macros.svh.
`include "odd_even_transposition_sort_macros.svh"

module oets_ctrl #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last_in,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 last_out,
  output logic                 overflow,
  output oets_pkg::cell_ctrl_t ctrl
);

  localparam oets_pkg::cnt_t MAX_C = oets_pkg::CNT_W'(MAX_ITEMS);
  localparam oets_pkg::cnt_t ONE_C = oets_pkg::CNT_W'(1);

  oets_pkg::state_t state, state_next;
  oets_pkg::cnt_t   count, count_next;
  oets_pkg::cnt_t   round, round_next;
  logic             dropped, dropped_next;
  logic             in_acc;
  logic             out_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= oets_pkg::ST_LOAD;
      count   <= '0;
      round   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      round   <= round_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    round_next   = round;
    dropped_next = dropped;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    ctrl.mode    = oets_pkg::MODE_HOLD;
    ctrl.parity  = round[0];
    ctrl.count   = count;
    in_acc       = 1'b0;
    out_acc      = 1'b0;
    case (state)
      oets_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        in_acc   = in_valid;
        if (in_acc) begin
          if (count < MAX_C) begin
            ctrl.mode  = oets_pkg::MODE_SHIFT_UP;
            count_next = count + ONE_C;
          end else begin
            dropped_next = 1'b1;
          end
          if (last_in) begin
            state_next = oets_pkg::ST_SORT;
            round_next = '0;
          end
        end
      end
      oets_pkg::ST_SORT: begin
        ctrl.mode  = oets_pkg::MODE_SORT;
        round_next = round + ONE_C;
        if (round_next >= count) begin
          state_next = oets_pkg::ST_EMIT;
        end
      end
      oets_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_acc   = out_ready;
        if (out_acc) begin
          ctrl.mode  = oets_pkg::MODE_SHIFT_DOWN;
          count_next = count - ONE_C;
          if (count == ONE_C) begin
            dropped_next = 1'b0;
            state_next   = oets_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_next = oets_pkg::ST_LOAD;
      end
    endcase
    last_out = count == ONE_C;
    overflow = dropped;
  end

  `OETS_ASSERT_ALWAYS(a_one_side, !(in_ready && out_valid), "load and unload overlap")
  `OETS_ASSERT_ALWAYS(a_count_max, count <= MAX_C, "count beyond capacity")
  `OETS_ASSERT_NEXT(a_last_ends, in_valid && in_ready && last_in, !in_ready && count != '0,
    "last request did not start sort")
  `OETS_ASSERT_NEXT(a_done_clear, out_valid && out_ready && last_out,
    in_ready && count == '0 && !overflow, "sequence end left state behind")

endmodule

FILE: bench/tb.sv
// Self-checking bench for odd_even_transposition_sort: directed table, then random sequences.
// Depends on oets_pkg and the sorter RTL; predicts each sorted sequence and checks every result.
module tb;
  typedef oets_pkg::data_t data_t;

  localparam int CAP = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 72;
  localparam data_t VMIN = data_t'(32'h8000_0000);
  localparam data_t VMAX = data_t'(32'h7FFF_FFFF);

  typedef struct packed {
    data_t value;
    logic  last;
    logic  ovf;
  } sorted_t;

  typedef struct packed {
    data_t   value;
    logic    last;
    logic    typed;
    sorted_t want;
  } request_row_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  data_t value;
  logic  last_in;
  logic  out_valid;
  logic  out_ready;
  data_t sorted_value;
  logic  last_out;
  logic  overflow;

  odd_even_transposition_sort #(.MAX_ITEMS(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .last_in(last_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sorted_value(sorted_value),
    .last_out(last_out),
    .overflow(overflow)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor state
  data_t   held_vals[$];
  logic    dropped_seen;
  sorted_t expected_sorted[$];

  int mismatches = 0;
  int send_idle;
  int recv_stall;
  logic in_fire;
  logic out_fire;
  int idle_cycles;
  request_row_t directed_rows [0:22];

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void predict_sequence(input data_t v, input logic last,
                                           ref sorted_t res[$]);
    data_t t;
    int n;
    res.delete();
    if (held_vals.size() < CAP) held_vals.push_back(v);
    else dropped_seen = 1'b1;
    if (!last) return;
    n = held_vals.size();
    for (int r = 0; r < n; r++) begin
      for (int j = r % 2; j + 1 < n; j += 2) begin
        if (held_vals[j] > held_vals[j+1]) begin
          t = held_vals[j];
          held_vals[j] = held_vals[j+1];
          held_vals[j+1] = t;
        end
      end
    end
    for (int k = 0; k < n; k++) res.push_back('{held_vals[k], k == n - 1, dropped_seen});
    held_vals.delete();
    dropped_seen = 1'b0;
  endfunction

  task automatic send_request(input data_t v, input logic last, input logic typed,
                              input sorted_t typed_want);
    sorted_t res[$];
    logic took;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    last_in <= last;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    predict_sequence(v, last, res);
    if (typed) expected_sorted.push_back(typed_want);
    else foreach (res[i]) expected_sorted.push_back(res[i]);
  endtask

  task automatic drain_results();
    while (expected_sorted.size() != 0) @(posedge clk);
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(0, 7))
      0: return VMIN;
      1: return VMAX;
      2: return data_t'(int'($urandom_range(0, 6)) - 3);
      default: return data_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(negedge clk) begin : result_check
    sorted_t want;
    in_fire = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    if (out_fire) begin
      if (expected_sorted.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending", sorted_value));
      end else begin
        want = expected_sorted.pop_front();
        if (sorted_value !== want.value)
          report_mismatch($sformatf("sorted_value %0d, want %0d", sorted_value, want.value));
        if (last_out !== want.last)
          report_mismatch($sformatf("last_out %b, want %b", last_out, want.last));
        if (overflow !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int seq_len;
    logic first_seq;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    last_in = 1'b0;
    dropped_seen = 1'b0;
    send_idle = 26;
    recv_stall = 52;
    // single-element sequences carry a typed result; the rest go through the predictor
    directed_rows = '{
      '{VMIN, 1'b1, 1'b1, '{VMIN, 1'b1, 1'b0}},
      '{VMAX, 1'b1, 1'b1, '{VMAX, 1'b1, 1'b0}},
      '{data_t'(0), 1'b1, 1'b1, '{data_t'(0), 1'b1, 1'b0}},
      '{data_t'(-1), 1'b1, 1'b1, '{data_t'(-1), 1'b1, 1'b0}},
      '{VMAX, 1'b0, 1'b0, '0},
      '{VMIN, 1'b1, 1'b0, '0},
      '{data_t'(5), 1'b0, 1'b0, '0},
      '{data_t'(5), 1'b0, 1'b0, '0},
      '{data_t'(5), 1'b1, 1'b0, '0},
      '{data_t'(4), 1'b0, 1'b0, '0},
      '{data_t'(3), 1'b0, 1'b0, '0},
      '{data_t'(2), 1'b0, 1'b0, '0},
      '{data_t'(1), 1'b0, 1'b0, '0},
      '{data_t'(-7), 1'b1, 1'b0, '0},
      '{VMIN, 1'b0, 1'b0, '0},
      '{data_t'(-1), 1'b0, 1'b0, '0},
      '{data_t'(0), 1'b0, 1'b0, '0},
      '{data_t'(1), 1'b0, 1'b0, '0},
      '{VMAX, 1'b1, 1'b0, '0},
      '{data_t'(32'h5555_5555), 1'b0, 1'b0, '0},
      '{data_t'(32'hAAAA_AAAA), 1'b0, 1'b0, '0},
      '{data_t'(32'h7FFF_FFFE), 1'b0, 1'b0, '0},
      '{data_t'(32'h8000_0001), 1'b1, 1'b0, '0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].value, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
    in_valid <= 1'b0;
    drain_results();

    // phase 0 opens with a full store, phase 1 with two dropped requests (the last one too)
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 26 : (ph == 1) ? 52 : 0;
      recv_stall = (ph == 0) ? 52 : (ph == 1) ? 26 : 0;
      sent = 0;
      first_seq = 1'b1;
      while (sent < RANDOM_PER_PHASE) begin
        if (first_seq && ph == 0) seq_len = CAP;
        else if (first_seq && ph == 1) seq_len = CAP + 2;
        else seq_len = $urandom_range(1, 10);
        first_seq = 1'b0;
        for (int k = 0; k < seq_len; k++) begin
          send_request(pick_value(), k == seq_len - 1, 1'b0, '0);
          sent++;
        end
      end
      in_valid <= 1'b0;
      drain_results();
    end

    repeat (2 * CAP + 8) @(posedge clk);
    if (mismatches == 0 && expected_sorted.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
